/* hdl/fof_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fof_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the friend-of-friend graph walk block.
// ----------------------------------------------------------------------------
package fof_pkg;

  localparam int USERS = 16;
  localparam int UW    = $clog2(USERS);   // node index width
  localparam int PW    = UW + 1;          // queue/stack pointer width
  localparam int CW    = 5;               // user_count register width
  localparam int FW    = 5;               // width of node fields on the input

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_BFS  = 2'd1;
  localparam logic [1:0] OP_DFS  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef logic [USERS-1:0] mask_t;

  typedef struct packed {
    logic accept;       // take the input item, start a walk or add an edge
    logic pop;          // fetch next node from the queue or stack
    logic scan;         // load the current node's row into the candidate set
    logic step;         // handle the lowest candidate
    logic load_single;  // output the single add-edge / invalid-index result
    logic load_final;   // output the held suggestion (or the empty result)
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic       in_ok;      // indices of the offered item are in range
    logic       more;       // queue or stack not empty
    logic       pend_none;  // no candidates left for the current node
    logic       cand_emit;  // lowest candidate is a suggestion
    logic       have_sugg;  // a suggestion is held back for its last flag
    logic       out_free;   // output register can take a result this cycle
  } dp_stat_t;

  function automatic logic [UW-1:0] lowest_index(input mask_t v);
    logic [UW-1:0] idx;
    idx = '0;
    for (int k = USERS - 1; k >= 0; k--) begin
      if (v[k]) idx = UW'(k);
    end
    return idx;
  endfunction

  function automatic mask_t node_bit(input logic [UW-1:0] i);
    return mask_t'(1) << i;
  endfunction

endpackage
`default_nettype wire

/* hdl/fof_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fof_ctrl
// Sequencer for the graph walk: accepts an item, then steps the datapath
// through pop / row scan / candidate loop and the final result.
// ----------------------------------------------------------------------------
module fof_ctrl
  import fof_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SINGLE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_CAND   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.in_op == OP_NONE) state_next = S_IDLE;
          else if (stat.in_op == OP_ADD || !stat.in_ok) state_next = S_SINGLE;
          else state_next = S_POP;
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.more) begin
          cmd.pop    = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_CAND;
      end
      S_CAND: begin
        if (stat.pend_none) begin
          state_next = S_POP;
        end else if (!(stat.cand_emit && stat.have_sugg && !stat.out_free)) begin
          // a new suggestion pushes the held one out, so wait for room
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.load_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

/* hdl/fof_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fof_dp
// Datapath: adjacency matrix, walk queue/stack, visit masks, candidate set,
// held suggestion and the output register.
// ----------------------------------------------------------------------------
module fof_dp
  import fof_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic [1:0]    in_op,
  input  wire logic [FW-1:0] in_first,
  input  wire logic [FW-1:0] in_second,
  input  wire logic [FW-1:0] in_query,
  input  wire dp_cmd_t       cmd,
  output dp_stat_t           stat,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [UW-1:0]      out_user,
  output logic               out_found,
  output logic               out_status,
  output logic               out_last
);

  logic [CW-1:0] user_count;
  logic [CW-1:0] n_eff;
  mask_t         nmask;

  mask_t         adjacency [USERS];
  logic [UW-1:0] walk_store [USERS];
  logic [PW-1:0] walk_head;
  logic [PW-1:0] walk_tail;
  mask_t         visited_mask;
  mask_t         reported_mask;
  mask_t         pending;
  mask_t         start_row;
  logic [UW-1:0] start_id;
  logic [UW-1:0] cur;
  logic          dfs;
  logic          single_status;
  logic [UW-1:0] sugg;
  logic          have_sugg;

  logic [UW-1:0] rd_idx;
  mask_t         rd_row;
  logic [UW-1:0] cand;
  logic          cand_emit;
  logic          out_free;
  logic          step_out;
  logic [PW-1:0] tail_dec;
  logic          ok_add, ok_walk;

  // effective node count and the mask of usable nodes
  always_comb begin
    n_eff = (user_count > CW'(USERS)) ? CW'(USERS) : user_count;
    for (int i = 0; i < USERS; i++) begin
      nmask[i] = CW'(i) < n_eff;
    end
  end

  assign ok_add  = (in_first < n_eff) && (in_second < n_eff);
  assign ok_walk = in_query < n_eff;

  assign rd_idx   = cmd.accept ? in_query[UW-1:0] : cur;
  assign rd_row   = adjacency[rd_idx];
  assign cand     = lowest_index(pending);
  assign cand_emit = !start_row[cand] && (cand != start_id) &&
                     !(dfs && reported_mask[cand]);
  assign out_free = !out_valid || out_ready;
  assign step_out = cmd.step && cand_emit && have_sugg;
  assign tail_dec = walk_tail - PW'(1);

  always_comb begin
    stat           = '0;
    stat.in_op     = in_op;
    stat.in_ok     = (in_op == OP_ADD) ? ok_add : ok_walk;
    stat.more      = dfs ? (walk_tail != '0) : (walk_head < walk_tail);
    stat.pend_none = (pending == '0);
    stat.cand_emit = cand_emit;
    stat.have_sugg = have_sugg;
    stat.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) user_count <= CW'(USERS);
    else if (cfg_we) user_count <= cfg_data;
  end

  // one update per row, so a self loop is a single write
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USERS; i++) adjacency[i] <= '0;
    end else if (cmd.accept && in_op == OP_ADD && ok_add) begin
      for (int i = 0; i < USERS; i++) begin
        if (in_first[UW-1:0] == UW'(i) || in_second[UW-1:0] == UW'(i)) begin
          adjacency[i] <= adjacency[i]
                          | ((in_first[UW-1:0] == UW'(i)) ?
                             node_bit(in_second[UW-1:0]) : '0)
                          | ((in_second[UW-1:0] == UW'(i)) ?
                             node_bit(in_first[UW-1:0]) : '0);
        end
      end
    end
  end

  // queue/stack entries: single write port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      walk_store[0] <= in_query[UW-1:0];
    end else if (cmd.step && walk_tail < PW'(USERS)) begin
      walk_store[walk_tail[UW-1:0]] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dfs           <= (in_op == OP_DFS);
      single_status <= (in_op == OP_ADD) ? !ok_add : !ok_walk;
      start_row     <= rd_row;
      start_id      <= in_query[UW-1:0];
    end
    if (cmd.pop) begin
      cur <= dfs ? walk_store[tail_dec[UW-1:0]] : walk_store[walk_head[UW-1:0]];
    end
    if (cmd.step && cand_emit) sugg <= cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_head     <= '0;
      walk_tail     <= '0;
      visited_mask  <= '0;
      reported_mask <= '0;
      pending       <= '0;
      have_sugg     <= 1'b0;
    end else if (cmd.accept) begin
      walk_head     <= '0;
      walk_tail     <= PW'(1);
      visited_mask  <= (in_op == OP_DFS) ? '0 : node_bit(in_query[UW-1:0]);
      reported_mask <= '0;
      pending       <= '0;
      have_sugg     <= 1'b0;
    end else if (cmd.pop) begin
      if (dfs) walk_tail <= tail_dec;
      else     walk_head <= walk_head + PW'(1);
    end else if (cmd.scan) begin
      if (dfs) begin
        // a node already expanded is skipped with an empty candidate set
        if (visited_mask[cur]) begin
          pending <= '0;
        end else begin
          visited_mask <= visited_mask | node_bit(cur);
          pending      <= rd_row & ~(visited_mask | node_bit(cur)) & nmask;
        end
      end else begin
        pending <= rd_row & ~visited_mask & nmask;
      end
    end else if (cmd.step) begin
      pending <= pending & ~node_bit(cand);
      if (!dfs) visited_mask <= visited_mask | node_bit(cand);
      if (walk_tail < PW'(USERS)) walk_tail <= walk_tail + PW'(1);
      if (cand_emit) begin
        have_sugg <= 1'b1;
        if (dfs) reported_mask <= reported_mask | node_bit(cand);
      end
    end else if (cmd.load_final) begin
      have_sugg <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_final || step_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_user   <= '0;
      out_found  <= 1'b0;
      out_status <= single_status;
      out_last   <= 1'b1;
    end else if (cmd.load_final) begin
      out_user   <= have_sugg ? sugg : '0;
      out_found  <= have_sugg;
      out_status <= 1'b0;
      out_last   <= 1'b1;
    end else if (step_out) begin
      out_user   <= sugg;
      out_found  <= 1'b1;
      out_status <= 1'b0;
      out_last   <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst)
    walk_tail <= PW'(USERS)) else $error("walk tail beyond capacity");

  a_head_tail: assert property (@(posedge clk) disable iff (rst)
    walk_head <= walk_tail) else $error("queue head passed tail");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_single || cmd.load_final || step_out) |-> out_free)
    else $error("result loaded over an untaken one");

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> nmask[cand] && pending[cand])
    else $error("candidate outside node range");
`endif

endmodule
`default_nettype wire

/* hdl/friend_of_friend_graph_walk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// friend_of_friend_graph_walk
// Friend-of-friend suggestion engine over a 16-node undirected graph.
//
// Input stream (s_*): one item per handshake. tuser carries the operation
// (add edge, breadth-first or depth-first suggest), tdata the node indices.
// Output stream (m_*): result items; tlast marks the final result of an item.
// cfg_we/cfg_data write user_count; the user must do so only while the block
// is idle, which the block itself does not enforce. One item is in work at a
// time; s_tready is high only between items. Add edge or invalid index: after
// accept the sequencer waits in its single result state until the output
// register is free, loads the result there and returns to idle for the next
// item. A walk pops each node from the queue or stack, reads its adjacency
// row, one row per visit, and steps through its newly discovered neighbors
// one at a time; accept, the empty check and finish frame this. Breadth first
// pops each node once. Depth first may pop a node again only to skip it, so a
// dense graph takes longer. Each suggestion is held one step so its tlast is
// known; a stalled m_tready stalls the walk when a new suggestion or the final
// result needs the output register. Reset (rst, synchronous) clears the
// adjacency matrix, sets user_count to 16 and leaves the output empty.
// ----------------------------------------------------------------------------
module friend_of_friend_graph_walk
  import fof_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data,   // user_count
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,    // edge_a[4:0], edge_b[9:5],
                                       // query_user[14:10], pad
  input  wire logic [1:0]  s_tuser,    // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // suggested_user[3:0], pad
  output logic [1:0]       m_tuser,    // found[0], status[1]
  output logic             m_tlast
);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [UW-1:0] out_user;
  logic          out_found;
  logic          out_status;

  fof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fof_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_op      (s_tuser),
    .in_first   (s_tdata[4:0]),
    .in_second  (s_tdata[9:5]),
    .in_query   (s_tdata[14:10]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_user   (out_user),
    .out_found  (out_found),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = {(8 - UW)'(0), out_user};
  assign m_tuser = {out_status, out_found};

endmodule
`default_nettype wire

/* dv/fof_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fof_checker
// Watches the config port and both streams of the friend-of-friend block,
// keeps its own copy of the graph and user count, predicts the result items
// of each accepted input item, and compares every accepted result in order.
// ----------------------------------------------------------------------------
module fof_checker
  import fof_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,    // edge_a[4:0], edge_b[9:5],
                                  // query_user[14:10], pad
  input  logic [1:0]  s_tuser,    // operation[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // suggested_user[3:0], pad
  input  logic [1:0]  m_tuser,    // found[0], status[1]
  input  logic        m_tlast,
  output int          mismatches,
  output int          pending,
  output int          results_checked,
  output int          suggestions_seen
);

  typedef struct packed {
    logic [3:0] suggested_user;
    logic       found;
    logic       status;
    logic       last;
  } walk_result_t;

  mask_t        links [USERS];
  logic [4:0]   active_users;
  walk_result_t expected_results [$];
  int           err_count;
  int           result_count;
  int           sugg_count;

  function automatic void push_result(logic [3:0] user, logic found, logic status,
                                      logic last);
    walk_result_t r;
    r.suggested_user = user;
    r.found          = found;
    r.status         = status;
    r.last           = last;
    expected_results.push_back(r);
  endfunction

  // Works out the suggestions of one item and updates the graph copy.
  function automatic void predict_suggestions(logic [1:0] op, logic [4:0] fu,
                                              logic [4:0] su, logic [4:0] qu);
    int         n;
    int         head;
    int         tail;
    int         cur;
    int         i;
    int         store [USERS];
    mask_t      seen;
    mask_t      told;
    logic [3:0] hits [$];

    n = (active_users > USERS) ? USERS : int'(active_users);
    if (op == OP_NONE) return;
    if (op == OP_ADD) begin
      if (fu < n && su < n) begin
        links[fu[3:0]][su[3:0]] = 1'b1;
        links[su[3:0]][fu[3:0]] = 1'b1;
        push_result(4'd0, 1'b0, 1'b0, 1'b1);
      end else begin
        push_result(4'd0, 1'b0, 1'b1, 1'b1);
      end
      return;
    end
    if (qu >= n) begin
      push_result(4'd0, 1'b0, 1'b1, 1'b1);
      return;
    end

    if (op == OP_BFS) begin
      seen = '0;
      seen[qu[3:0]] = 1'b1;
      head = 0;
      store[0] = qu;
      tail = 1;
      while (head < tail && head < USERS) begin
        cur = store[head];
        head++;
        for (i = 0; i < n; i++) begin
          if (links[cur][i] && !seen[i]) begin
            seen[i] = 1'b1;
            if (tail < USERS) begin
              store[tail] = i;
              tail++;
            end
            if (i != qu && !links[qu[3:0]][i]) hits.push_back(4'(i));
          end
        end
      end
    end else begin
      // depth first: a node is marked when popped, so it may sit on the
      // stack more than once; pushes past a full stack are lost
      seen = '0;
      told = '0;
      store[0] = qu;
      tail = 1;
      while (tail > 0) begin
        tail--;
        cur = store[tail];
        if (!seen[cur]) begin
          seen[cur] = 1'b1;
          for (i = 0; i < n; i++) begin
            if (links[cur][i] && !seen[i]) begin
              if (tail < USERS) begin
                store[tail] = i;
                tail++;
              end
              if (i != qu && !links[qu[3:0]][i] && !told[i]) begin
                told[i] = 1'b1;
                hits.push_back(4'(i));
              end
            end
          end
        end
      end
    end

    if (hits.size() == 0) begin
      push_result(4'd0, 1'b0, 1'b0, 1'b1);
    end else begin
      foreach (hits[k]) push_result(hits[k], 1'b1, 1'b0, k == hits.size() - 1);
    end
  endfunction

  always @(posedge clk) begin
    walk_result_t want;
    if (rst) begin
      foreach (links[k]) links[k] = '0;
      active_users = 5'd16;
      expected_results.delete();
      err_count    = 0;
      result_count = 0;
      sugg_count   = 0;
    end else begin
      if (cfg_we) active_users = cfg_data;
      if (s_tvalid && s_tready)
        predict_suggestions(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[14:10]);
      if (m_tvalid && m_tready) begin
        result_count++;
        if (m_tuser[0]) sugg_count++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: user %0d found %0b status %0b last %0b",
                 m_tdata[3:0], m_tuser[0], m_tuser[1], m_tlast);
          err_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[3:0] !== want.suggested_user) begin
            $error("suggested_user: expected %0d, actual %0d", want.suggested_user,
                   m_tdata[3:0]);
            err_count++;
          end
          if (m_tuser[0] !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, m_tuser[0]);
            err_count++;
          end
          if (m_tuser[1] !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, m_tuser[1]);
            err_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_tlast);
            err_count++;
          end
        end
      end
    end
    mismatches       <= err_count;
    pending          <= expected_results.size();
    results_checked  <= result_count;
    suggestions_seen <= sugg_count;
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the friend-of-friend block with a directed graph that reaches the
// walk corner cases, then random edge and query traffic under several user
// counts and idle/stall patterns. fof_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import fof_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;     // edge_a[4:0], edge_b[9:5],
                                 // query_user[14:10], pad
  logic [1:0]  s_tuser = '0;     // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // suggested_user[3:0], pad
  logic [1:0]  m_tuser;          // found[0], status[1]
  logic        m_tlast;

  int mismatches;
  int pending;
  int results_checked;
  int suggestions_seen;

  int idle_pct  = 0;
  int stall_pct = 0;
  int add_count = 0;
  int bfs_count = 0;
  int dfs_count = 0;
  int nop_count = 0;

  friend_of_friend_graph_walk dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  fof_checker u_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .m_tlast          (m_tlast),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_checked  (results_checked),
    .suggestions_seen (suggestions_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [1:0] op, input logic [4:0] fu,
                           input logic [4:0] su, input logic [4:0] qu);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, qu, su, fu};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      OP_ADD:  add_count++;
      OP_BFS:  bfs_count++;
      OP_DFS:  dfs_count++;
      default: nop_count++;
    endcase
  endtask

  // Sender holds off until every expected item is back and the block is idle.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_user_count(input logic [4:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly in-range edges to near nodes (keeps the graph sparse enough for
  // suggestions) and in-range queries; the rest is unrestricted noise.
  task automatic random_phase(input int items, input int count_raw,
                              input int send_idle, input int recv_stall);
    int         n;
    int         sent;
    int         pick;
    logic [1:0] op;
    logic [4:0] fu;
    logic [4:0] su;
    logic [4:0] qu;
    n = (count_raw > USERS) ? USERS : count_raw;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      fu = 5'($urandom);
      su = 5'($urandom);
      qu = 5'($urandom);
      if (n == 0 || pick < 12) begin
        op = 2'($urandom);
      end else if (pick < 40) begin
        op = OP_ADD;
        fu = 5'($urandom_range(n - 1));
        if (pick < 36) su = 5'((int'(fu) + int'($urandom_range(3, 1))) % n);
        else su = 5'($urandom_range(n - 1));
      end else begin
        op = (pick < 70) ? OP_BFS : OP_DFS;
        qu = 5'($urandom_range(n - 1));
      end
      send_item(op, fu, su, qu);
      if (op != OP_NONE) sent++;
    end
    drain();
  endtask

  initial begin
    #8_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty graph walks, self loop, a hub whose last-pushed
    // neighbor overflows the depth-first stack, bad indices, unused op
    send_item(OP_DFS, 5'd0, 5'd0, 5'd0);
    send_item(OP_BFS, 5'd31, 5'd31, 5'd15);
    send_item(OP_ADD, 5'd0, 5'd0, 5'd0);
    send_item(OP_ADD, 5'd0, 5'd1, 5'd0);
    for (int k = 2; k < USERS; k++) send_item(OP_ADD, 5'd1, 5'(k), 5'd0);
    for (int k = 2; k < 6; k++) send_item(OP_ADD, 5'd15, 5'(k), 5'd0);
    send_item(OP_BFS, 5'd0, 5'd0, 5'd0);
    send_item(OP_DFS, 5'd0, 5'd0, 5'd0);
    send_item(OP_BFS, 5'd0, 5'd0, 5'd31);
    send_item(OP_ADD, 5'd16, 5'd31, 5'd0);
    send_item(OP_ADD, 5'd5, 5'd16, 5'd0);
    send_item(OP_NONE, 5'd31, 5'd31, 5'd31);
    drain();

    // counts above the node total act as the full graph
    write_user_count(5'd31);
    random_phase(100, 31, 0, 0);
    write_user_count(5'd9);
    random_phase(100, 9, 84, 0);
    write_user_count(5'd0);
    random_phase(15, 0, 0, 84);
    write_user_count(5'd12);
    random_phase(100, 12, 0, 84);
    write_user_count(5'd16);
    random_phase(100, 16, 33, 33);
    write_user_count(5'd1);
    random_phase(15, 1, 0, 0);

    $display("run: %0d adds, %0d breadth-first and %0d depth-first walks, %0d unused-op items",
             add_count, bfs_count, dfs_count, nop_count);
    $display("run: %0d result items checked, %0d of them suggestions, user counts 0 to 31",
             results_checked, suggestions_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
